FILE: hw/rtl/e1fma_pkg.sv
// e1fma_pkg: shared types, constants and the crc-4 byte update for the e1 aligner
// no dependencies; imported by every module of the block
`default_nettype none

package e1fma_pkg;

  localparam int SLOTS_PER_FRAME = 32;
  localparam int HIST_DEPTH      = 16;
  localparam int SCOUNT_W        = 7;

  localparam logic [4:0] SLOT_TS0  = 5'd0;
  localparam logic [4:0] SLOT_LAST = 5'(SLOTS_PER_FRAME - 1);

  localparam logic [6:0] FAS_PATTERN = 7'h1B;
  localparam int         A_BIT_POS   = 5;

  localparam logic [1:0] ALIGN_FRAME_HUNT    = 2'd0;
  localparam logic [1:0] ALIGN_SEARCH_MFRAME = 2'd1;
  localparam logic [1:0] ALIGN_CRC_ALIGNED   = 2'd2;
  localparam logic [1:0] ALIGN_BASIC_ALIGNED = 2'd3;

  localparam logic [3:0] FC_AFTER_FAS = 4'd2;
  localparam logic [3:0] FC_AFTER_MF  = 4'd11;
  localparam logic [3:0] FC_CRC_SMF1  = 4'd7;
  localparam logic [3:0] FC_CRC_SMF2  = 4'd15;
  localparam logic [3:0] FC_EBIT_1    = 4'd13;
  localparam logic [3:0] FC_EBIT_2    = 4'd15;

  typedef struct packed {
    logic [7:0] octet;
    logic [4:0] slot_index;
  } octet_item_t;

  typedef struct packed {
    logic [1:0] align_state;
    logic [3:0] frame_number;
    logic       frame_found;
    logic       mframe_found;
    logic       local_crc_error;
    logic       local_crc_changed;
    logic       remote_crc_error;
    logic       remote_crc_changed;
    logic       far_alarm;
    logic       far_alarm_changed;
  } status_t;

  // history seen relative to the current frame counter: bit k is frame (fc - k)
  typedef struct packed {
    logic [HIST_DEPTH-1:0] fas;
    logic [HIST_DEPTH-1:0] top;
  } hist_view_t;

  typedef struct packed {
    logic       upd;
    logic [3:0] rot;
  } hist_ctl_t;

  function automatic logic is_fas(input logic [7:0] b);
    return b[6:0] == FAS_PATTERN;
  endfunction

  // x^4+x+1, msb first
  function automatic logic [3:0] crc4_byte(input logic [3:0] crc, input logic [7:0] b);
    logic [3:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[3] ^ b[i];
      c  = {c[2:0], 1'b0} ^ {2'b00, fb, fb};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/e1fma_stream_if.sv
// e1fma_stream_if: valid/ready channel carrying one payload per request
// payload type given by parameter; no other dependencies
`default_nettype none

interface e1fma_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/e1fma_crc4.sv
// e1fma_crc4: running crc-4 over every octet and the crc of the last sub-multiframe
// depends on e1fma_pkg
`default_nettype none

module e1fma_crc4 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] octet,
  input  wire logic       ts0,
  input  wire logic       check,
  output logic [3:0]      previous_crc
);
  import e1fma_pkg::*;

  logic [3:0] running_crc;
  logic [7:0] crc_in;
  logic [3:0] crc_upd;

  // c bit masked in a fas octet
  assign crc_in  = (ts0 && is_fas(octet)) ? {1'b0, octet[6:0]} : octet;
  assign crc_upd = crc4_byte(running_crc, crc_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= '0;
      previous_crc <= '0;
    end else if (step) begin
      if (check) begin
        previous_crc <= crc_upd;
        running_crc  <= '0;
      end else begin
        running_crc <= crc_upd;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/e1fma_ts0_hist.sv
// e1fma_ts0_hist: 16-frame ts0 history, kept rotated to the frame counter
// depends on e1fma_pkg; rotation amount comes from the alignment machine
`default_nettype none

module e1fma_ts0_hist (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            latched_ts0,
  input  wire e1fma_pkg::hist_ctl_t  ctl,
  output e1fma_pkg::hist_view_t      view
);
  import e1fma_pkg::*;

  logic [HIST_DEPTH-1:0] fas_q;
  logic [HIST_DEPTH-1:0] top_q;
  logic [HIST_DEPTH-1:0] fas_next;
  logic [HIST_DEPTH-1:0] top_next;

  // entry of the current frame replaced by this frame's ts0
  assign view.fas = {fas_q[HIST_DEPTH-1:1], is_fas(latched_ts0)};
  assign view.top = {top_q[HIST_DEPTH-1:1], latched_ts0[7]};

  always_comb begin
    logic [3:0] idx;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      idx         = 4'(k) + ctl.rot;
      fas_next[k] = view.fas[idx];
      top_next[k] = view.top[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fas_q <= '0;
      top_q <= '0;
    end else if (ctl.upd) begin
      fas_q <= fas_next;
      top_q <= top_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/e1fma_align.sv
// e1fma_align: g.706 frame / crc-4 multiframe alignment machine and alarm levels
// depends on e1fma_pkg; fed by e1fma_ts0_hist and e1fma_crc4
`default_nettype none

module e1fma_align #(
  parameter int MFRAME_SEARCH_LIMIT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  frame_end,
  input  wire logic                  crc4_enable,
  input  wire logic [7:0]            latched_ts0,
  input  wire e1fma_pkg::hist_view_t view,
  input  wire logic [3:0]            previous_crc,
  output e1fma_pkg::hist_ctl_t       hist_ctl,
  output logic                       crc_check,
  output e1fma_pkg::status_t         status
);
  import e1fma_pkg::*;

  typedef enum logic [1:0] {
    FRAME_HUNT    = ALIGN_FRAME_HUNT,
    SEARCH_MFRAME = ALIGN_SEARCH_MFRAME,
    CRC_ALIGNED   = ALIGN_CRC_ALIGNED,
    BASIC_ALIGNED = ALIGN_BASIC_ALIGNED
  } mode_t;

  mode_t               mode, mode_next;
  logic [3:0]          fc, fc_mid, fc_next;
  logic [SCOUNT_W-1:0] scount, scount_next;
  logic                crc_err, crc_err_next;
  logic                rem_err, rem_err_next;
  logic                alarm, alarm_next;
  logic                ff, mf, lchg, rchg, achg, check;
  logic                lost, recovered, mf_seen;
  logic [3:0]          rx_crc;

  assign lost      = !fc[0] && !view.fas[0] && !view.fas[2] && !view.fas[4];
  assign recovered = view.fas[0] && !view.fas[1] && view.fas[2];
  assign mf_seen   = !view.fas[0] && view.top[0] && view.top[2] && !view.top[4] &&
                     view.top[6] && !view.top[8] && !view.top[10];
  assign rx_crc    = {view.top[7], view.top[5], view.top[3], view.top[1]};

  always_comb begin
    mode_next    = mode;
    fc_mid       = fc;
    scount_next  = scount;
    crc_err_next = crc_err;
    rem_err_next = rem_err;
    alarm_next   = alarm;
    ff           = 1'b0;
    mf           = 1'b0;
    lchg         = 1'b0;
    rchg         = 1'b0;
    achg         = 1'b0;
    check        = 1'b0;
    unique case (mode)
      FRAME_HUNT: begin
        if (recovered) begin
          fc_mid      = FC_AFTER_FAS;
          ff          = 1'b1;
          scount_next = '0;
          mode_next   = crc4_enable ? SEARCH_MFRAME : BASIC_ALIGNED;
        end
      end
      SEARCH_MFRAME: begin
        if (!crc4_enable) begin
          mode_next = BASIC_ALIGNED;
        end else if (mf_seen) begin
          fc_mid    = FC_AFTER_MF;
          mf        = 1'b1;
          mode_next = CRC_ALIGNED;
        end else if (scount >= SCOUNT_W'(MFRAME_SEARCH_LIMIT)) begin
          scount_next = '0;
          mode_next   = FRAME_HUNT;
        end else begin
          scount_next = scount + 1'b1;
        end
      end
      CRC_ALIGNED, BASIC_ALIGNED: begin
        if (lost) begin
          mode_next = FRAME_HUNT;
        end else begin
          if (mode == CRC_ALIGNED && crc4_enable) begin
            if (fc == FC_CRC_SMF1 || fc == FC_CRC_SMF2) begin
              crc_err_next = rx_crc != previous_crc;
              lchg         = crc_err_next ^ crc_err;
              check        = 1'b1;
            end
            if (fc == FC_EBIT_1 || fc == FC_EBIT_2) begin
              rem_err_next = !view.top[0];
              rchg         = rem_err_next ^ rem_err;
            end
          end
          if (!view.fas[0]) begin
            alarm_next = latched_ts0[A_BIT_POS];
          end
          achg = alarm_next ^ alarm;
        end
      end
      default: begin
        mode_next = FRAME_HUNT;
      end
    endcase
    fc_next = fc_mid + 4'd1;
  end

  assign hist_ctl.upd = frame_end;
  assign hist_ctl.rot = fc - fc_next;
  assign crc_check    = frame_end && check;

  assign status.align_state        = mode_next;
  assign status.frame_number       = fc_next;
  assign status.frame_found        = ff;
  assign status.mframe_found       = mf;
  assign status.local_crc_error    = crc_err_next;
  assign status.local_crc_changed  = lchg;
  assign status.remote_crc_error   = rem_err_next;
  assign status.remote_crc_changed = rchg;
  assign status.far_alarm          = alarm_next;
  assign status.far_alarm_changed  = achg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= FRAME_HUNT;
      fc      <= '0;
      scount  <= '0;
      crc_err <= 1'b0;
      rem_err <= 1'b0;
      alarm   <= 1'b0;
    end else if (frame_end) begin
      mode    <= mode_next;
      fc      <= fc_next;
      scount  <= scount_next;
      crc_err <= crc_err_next;
      rem_err <= rem_err_next;
      alarm   <= alarm_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/e1_frame_multiframe_aligner_unit.sv
// e1_frame_multiframe_aligner_unit: e1 receive frame and crc-4 multiframe aligner, top level
// depends on e1fma_pkg, e1fma_stream_if, e1fma_crc4, e1fma_ts0_hist, e1fma_align
//
// Octets enter one per request with their timeslot number and are taken at one per clock
// cycle while the input side does not stall. Each octet is held in an input register; as it
// leaves, it updates the running crc-4 and, for the last timeslot of a frame, runs the
// alignment machine and loads one status request into the output register. Other timeslots
// give no status. The input side stalls only when a frame-closing octet meets an output
// register that is still full. The user must write crc4_enable (reset 1) through cfg only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module e1_frame_multiframe_aligner_unit #(
  parameter int MFRAME_SEARCH_LIMIT = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  e1fma_stream_if.sink    octets,
  e1fma_stream_if.source  status,
  e1fma_stream_if.sink    cfg
);
  import e1fma_pkg::*;

  logic        crc4_enable;
  logic        s1_valid;
  octet_item_t s1_item;
  logic        s1_last;
  logic        s1_adv;
  logic        frame_end;
  logic [7:0]  latched_ts0;
  logic        out_valid;
  status_t     out_data;

  hist_view_t  view;
  hist_ctl_t   hist_ctl;
  logic        crc_check;
  logic [3:0]  previous_crc;
  status_t     frame_status;

  assign s1_last      = s1_item.slot_index == SLOT_LAST;
  assign s1_adv       = s1_valid && (!s1_last || !out_valid || status.ready);
  assign frame_end    = s1_adv && s1_last;
  assign octets.ready = !s1_valid || s1_adv;
  assign cfg.ready    = 1'b1;
  assign status.valid = out_valid;
  assign status.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc4_enable <= 1'b1;
    end else if (cfg.valid) begin
      crc4_enable <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (octets.ready) begin
      s1_valid <= octets.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (octets.ready && octets.valid) begin
      s1_item <= octets.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_ts0 <= '0;
    end else if (s1_adv && s1_item.slot_index == SLOT_TS0) begin
      latched_ts0 <= s1_item.octet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_end) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_data <= frame_status;
    end
  end

  e1fma_crc4 u_crc4 (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .octet        (s1_item.octet),
    .ts0          (s1_item.slot_index == SLOT_TS0),
    .check        (crc_check),
    .previous_crc (previous_crc)
  );

  e1fma_ts0_hist u_hist (
    .clk         (clk),
    .rst         (rst),
    .latched_ts0 (latched_ts0),
    .ctl         (hist_ctl),
    .view        (view)
  );

  e1fma_align #(
    .MFRAME_SEARCH_LIMIT (MFRAME_SEARCH_LIMIT)
  ) u_align (
    .clk          (clk),
    .rst          (rst),
    .frame_end    (frame_end),
    .crc4_enable  (crc4_enable),
    .latched_ts0  (latched_ts0),
    .view         (view),
    .previous_crc (previous_crc),
    .hist_ctl     (hist_ctl),
    .crc_check    (crc_check),
    .status       (frame_status)
  );

  a_mf_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mframe_found |->
      out_data.align_state == ALIGN_CRC_ALIGNED && out_data.frame_number == 4'd12)
    else $error("multiframe found without crc aligned state");

  a_ff_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_found |->
      out_data.frame_number == 4'd3 &&
      (out_data.align_state == ALIGN_SEARCH_MFRAME ||
       out_data.align_state == ALIGN_BASIC_ALIGNED))
    else $error("frame found with wrong state or frame number");

  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_found && out_data.mframe_found))
    else $error("frame and multiframe found together");

  a_crc_chg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.local_crc_changed || out_data.remote_crc_changed) |->
      out_data.align_state == ALIGN_CRC_ALIGNED)
    else $error("crc level change outside crc aligned state");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.ready |=> out_valid && $stable(out_data))
    else $error("pending status lost");

endmodule

`default_nettype wire

FILE: verif/e1_frame_multiframe_aligner_unit_tb.sv
// testbench for e1_frame_multiframe_aligner_unit: self-checking, random frame streams
// needs e1fma_pkg, e1fma_stream_if and the rtl of the aligner; own aligner predictor inside
`timescale 1ns / 100ps

module e1_frame_multiframe_aligner_unit_tb;
  import e1fma_pkg::*;

  localparam int          MF_SEARCH_LIMIT = 64;
  localparam int          RANDOM_OCTETS   = 1800;
  localparam int          IDLE_SETTLE     = 6;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam logic [5:0]  MFAS_BITS       = 6'b110100;

  typedef struct {
    octet_item_t item;
    bit          closes;
    status_t     st;
  } octet_req_t;

  logic clk;
  logic rst;

  e1fma_stream_if #(.payload_t(octet_item_t)) octets ();
  e1fma_stream_if #(.payload_t(status_t))     status ();
  e1fma_stream_if                             cfg ();

  e1_frame_multiframe_aligner_unit #(
    .MFRAME_SEARCH_LIMIT(MF_SEARCH_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .octets(octets),
    .status(status),
    .cfg   (cfg)
  );

  // predictor state
  logic       crc4_on;
  logic [1:0] aln_mode;
  logic [3:0] frame_no;
  logic [7:0] ts0_hist [16];
  logic [7:0] ts0_latch;
  logic [3:0] crc_run;
  logic [3:0] crc_prev;
  logic [6:0] srch_cnt;
  logic       lcrc_flag;
  logic       rcrc_flag;
  logic       alarm_lvl;

  // line generator state
  logic [3:0]  line_pos;
  logic        remote_a;
  bit          mf_on;
  int unsigned noise_pct;
  int unsigned outage_left;
  int unsigned octets_made;

  octet_req_t  octet_backlog [$];
  status_t     status_due [$];
  octet_req_t  cur_req;
  bit          offering;
  int unsigned burst_left = 1;
  int unsigned gap_left;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned hold_left;
  int unsigned ready_tick;
  int unsigned stall_mode;
  int unsigned cycle_count;
  logic        rdy;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit fas_octet(input logic [7:0] b);
    return b[6:0] == FAS_PATTERN;
  endfunction

  function automatic logic [3:0] crc4_next(input logic [3:0] c, input logic [7:0] b);
    logic msb;
    for (int i = 7; i >= 0; i--) begin
      msb = c[3] ^ b[i];
      c   = c << 1;
      if (msb) c = c ^ 4'b0011;
    end
    return c;
  endfunction

  function automatic logic [7:0] hist_at(input int d);
    return ts0_hist[frame_no - 4'(d)];
  endfunction

  task automatic aligner_reset();
    crc4_on   = 1'b1;
    aln_mode  = ALIGN_FRAME_HUNT;
    frame_no  = '0;
    foreach (ts0_hist[i]) ts0_hist[i] = '0;
    ts0_latch = '0;
    crc_run   = '0;
    crc_prev  = '0;
    srch_cnt  = '0;
    lcrc_flag = 1'b0;
    rcrc_flag = 1'b0;
    alarm_lvl = 1'b0;
  endtask

  task automatic align_step(input logic [7:0] oct, input logic [4:0] slot,
                            output bit closes, output status_t st);
    bit         ff, mf, lchg, rchg, achg, err, lost, seen_mf;
    logic [7:0] h0, h2, h4, h6, h8, h10;
    logic [3:0] rx, base;
    ff = 0; mf = 0; lchg = 0; rchg = 0; achg = 0;
    st = '0;
    if (slot == SLOT_TS0) begin
      ts0_latch = oct;
      crc_run   = crc4_next(crc_run, fas_octet(oct) ? {1'b0, oct[6:0]} : oct);
    end else begin
      crc_run = crc4_next(crc_run, oct);
    end
    closes = (slot == SLOT_LAST);
    if (closes) begin
      ts0_hist[frame_no] = ts0_latch;
      h0      = hist_at(0);
      h2      = hist_at(2);
      h4      = hist_at(4);
      h6      = hist_at(6);
      h8      = hist_at(8);
      h10     = hist_at(10);
      lost    = !frame_no[0] && !fas_octet(h0) && !fas_octet(h2) && !fas_octet(h4);
      seen_mf = !fas_octet(h0) && h0[7] && h2[7] && !h4[7] &&
                h6[7] && !h8[7] && !h10[7];
      case (aln_mode)
        ALIGN_FRAME_HUNT: begin
          if (fas_octet(h0) && !fas_octet(hist_at(1)) && fas_octet(h2)) begin
            frame_no = FC_AFTER_FAS;
            ff       = 1;
            srch_cnt = '0;
            aln_mode = crc4_on ? ALIGN_SEARCH_MFRAME : ALIGN_BASIC_ALIGNED;
          end
        end
        ALIGN_SEARCH_MFRAME: begin
          if (!crc4_on) begin
            aln_mode = ALIGN_BASIC_ALIGNED;
          end else if (seen_mf) begin
            frame_no = FC_AFTER_MF;
            mf       = 1;
            aln_mode = ALIGN_CRC_ALIGNED;
          end else if (srch_cnt >= MF_SEARCH_LIMIT) begin
            srch_cnt = '0;
            aln_mode = ALIGN_FRAME_HUNT;
          end else begin
            srch_cnt = srch_cnt + 7'd1;
          end
        end
        default: begin
          if (lost) begin
            aln_mode = ALIGN_FRAME_HUNT;
          end else begin
            if (aln_mode == ALIGN_CRC_ALIGNED && crc4_on) begin
              if (frame_no == FC_CRC_SMF1 || frame_no == FC_CRC_SMF2) begin
                base      = (frame_no == FC_CRC_SMF2) ? 4'd8 : 4'd0;
                rx        = {ts0_hist[base][7], ts0_hist[base + 4'd2][7],
                             ts0_hist[base + 4'd4][7], ts0_hist[base + 4'd6][7]};
                err       = rx != crc_prev;
                lchg      = err != lcrc_flag;
                lcrc_flag = err;
                crc_prev  = crc_run;
                crc_run   = '0;
              end
              if (frame_no == FC_EBIT_1 || frame_no == FC_EBIT_2) begin
                err       = !h0[7];
                rchg      = err != rcrc_flag;
                rcrc_flag = err;
              end
            end
            if (!fas_octet(h0)) begin
              achg      = h0[A_BIT_POS] != alarm_lvl;
              alarm_lvl = h0[A_BIT_POS];
            end
          end
        end
      endcase
      frame_no = frame_no + 4'd1;
      st.align_state        = aln_mode;
      st.frame_number       = frame_no;
      st.frame_found        = ff;
      st.mframe_found       = mf;
      st.local_crc_error    = lcrc_flag;
      st.local_crc_changed  = lchg;
      st.remote_crc_error   = rcrc_flag;
      st.remote_crc_changed = rchg;
      st.far_alarm          = alarm_lvl;
      st.far_alarm_changed  = achg;
    end
  endtask

  task automatic emit(input logic [7:0] oct, input logic [4:0] slot);
    octet_req_t r;
    r.item.octet      = oct;
    r.item.slot_index = slot;
    align_step(oct, slot, r.closes, r.st);
    octet_backlog.push_back(r);
    octets_made++;
  endtask

  // one frame of the far-end line, with the odd fault thrown in
  task automatic send_frame();
    logic [7:0]  ts0;
    logic        top;
    int unsigned trouble;
    int          idx;
    trouble = 99;
    if ($urandom_range(0, 99) < noise_pct) trouble = $urandom_range(0, 5);
    if (!line_pos[0]) begin
      idx = 3 - int'(frame_no[2:1]);
      if (aln_mode == ALIGN_CRC_ALIGNED && !frame_no[0] && $urandom_range(0, 3) != 0)
        top = crc_prev[idx];
      else
        top = 1'($urandom);
      ts0 = {top, FAS_PATTERN};
    end else begin
      if ($urandom_range(0, 9) == 0) remote_a = ~remote_a;
      if (!mf_on) top = 1'b1;
      else if (line_pos >= 4'd13) top = $urandom_range(0, 3) != 0;
      else top = MFAS_BITS[(line_pos - 4'd1) >> 1];
      ts0 = {top, 1'b1, remote_a, 5'($urandom)};
    end
    if (outage_left > 0) begin
      ts0 = 8'($urandom);
      outage_left--;
    end
    if (trouble == 0) ts0 = 8'($urandom);
    if (trouble == 3) outage_left = $urandom_range(3, 6);
    if (trouble != 1) emit(ts0, SLOT_TS0);
    if (trouble == 5) emit(8'($urandom), SLOT_LAST);
    if (trouble == 4) begin
      repeat ($urandom_range(2, 6)) emit(8'($urandom), 5'($urandom_range(0, 30)));
    end else if ($urandom_range(0, 7) == 0) begin
      for (int s = 1; s < SLOTS_PER_FRAME - 1; s++) emit(8'($urandom), 5'(s));
    end else begin
      repeat ($urandom_range(0, 3)) emit(8'($urandom), 5'($urandom_range(1, 30)));
    end
    emit(8'($urandom), SLOT_LAST);
    if (trouble != 2) line_pos = line_pos + 4'd1;
  endtask

  task automatic run_line(input int frames, input logic [1:0] stop_state);
    int extra;
    repeat (frames) send_frame();
    extra = 0;
    while (aln_mode != stop_state && extra < 150) begin
      send_frame();
      extra++;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (octet_backlog.size() != 0 || offering || status_due.size() != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_crc4(input logic v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk);
    while (!cfg.ready);
    cfg.valid <= 1'b0;
    crc4_on = v;
  endtask

  task automatic field_check(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns status %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_status(input status_t got);
    status_t want;
    if (status_due.size() == 0) begin
      mismatches++;
      $display("%0t ns status request with none outstanding: expected none, got %p",
               $time, got);
    end else begin
      want = status_due.pop_front();
      field_check("align_state", 4'(want.align_state), 4'(got.align_state));
      field_check("frame_number", want.frame_number, got.frame_number);
      field_check("frame_found", 4'(want.frame_found), 4'(got.frame_found));
      field_check("mframe_found", 4'(want.mframe_found), 4'(got.mframe_found));
      field_check("local_crc_error", 4'(want.local_crc_error),
                  4'(got.local_crc_error));
      field_check("local_crc_changed", 4'(want.local_crc_changed),
                  4'(got.local_crc_changed));
      field_check("remote_crc_error", 4'(want.remote_crc_error),
                  4'(got.remote_crc_error));
      field_check("remote_crc_changed", 4'(want.remote_crc_changed),
                  4'(got.remote_crc_changed));
      field_check("far_alarm", 4'(want.far_alarm), 4'(got.far_alarm));
      field_check("far_alarm_changed", 4'(want.far_alarm_changed),
                  4'(got.far_alarm_changed));
    end
  endtask

  // octet driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      octets.valid <= 1'b0;
      octets.data  <= '0;
    end else begin
      if (octets.valid && octets.ready) begin
        if (cur_req.closes) status_due.push_back(cur_req.st);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (octet_backlog.size() > 0) begin
          cur_req  = octet_backlog.pop_front();
          offering = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      octets.valid <= offering;
      octets.data  <= cur_req.item;
    end
  end

  // status monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      status.ready <= 1'b0;
    end else begin
      if (status.valid && status.ready) begin
        check_status(status.data);
        results_seen++;
        // long hold-off so the block backs up into the octet side
        if (results_seen == 40 || results_seen == 200) hold_left = 300;
      end
      if (ready_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      ready_tick++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom);
          2: rdy = $urandom_range(0, 3) == 0;
          default: rdy = (ready_tick % 3) != 0;
        endcase
      end
      status.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("e1_frame_multiframe_aligner_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg.valid    = 1'b0;
    cfg.data     = 1'b0;
    aligner_reset();
    line_pos    = '0;
    remote_a    = 1'b0;
    mf_on       = 1;
    noise_pct   = 0;
    outage_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // field extremes, frame acquisition, missing ts0, jumbled slots
    emit(8'hFF, 5'd0);  emit(8'h00, SLOT_LAST);
    emit(8'h9B, 5'd0);  emit(8'hA5, 5'd17); emit(8'h5A, SLOT_LAST);
    emit(8'hC0, 5'd0);  emit(8'h80, SLOT_LAST);
    emit(8'h1B, 5'd0);  emit(8'hFF, 5'd30); emit(8'h00, SLOT_LAST);
    emit(8'h3C, SLOT_LAST);
    emit(8'h12, 5'd5);  emit(8'hE0, 5'd0);  emit(8'h7F, 5'd3);
    emit(8'h01, 5'd1);  emit(8'hFE, SLOT_LAST);
    emit(8'h9B, 5'd0);  emit(8'h1B, SLOT_LAST);

    write_crc4(1'b1);
    noise_pct = 10;
    run_line(70, ALIGN_CRC_ALIGNED);

    write_crc4(1'b0);
    noise_pct = 15;
    run_line(40, ALIGN_BASIC_ALIGNED);

    // no multiframe signal, so the search runs out
    write_crc4(1'b1);
    mf_on     = 0;
    noise_pct = 0;
    run_line(80, ALIGN_SEARCH_MFRAME);

    write_crc4(1'b0);
    mf_on     = 1;
    noise_pct = 20;
    run_line(30, ALIGN_BASIC_ALIGNED);

    write_crc4(1'b1);
    noise_pct = 12;
    while (octets_made < RANDOM_OCTETS + 20) send_frame();

    wait_drained();
    if (mismatches == 0)
      $display("e1_frame_multiframe_aligner_unit verification clean");
    else
      $display("e1_frame_multiframe_aligner_unit verification failed");
    $finish;
  end

endmodule
